@@ rtl/bdrd_pkg.sv @@
// Shared types, constants and calendar helpers for the business-day return date block.
// Used by bdrd_mul, bdrd_cal and business_day_return_date_top; no dependencies.
package bdrd_pkg;

  // Field widths
  localparam int DAYS_WIDTH = 12;
  localparam int DAY_W      = 5;
  localparam int MON_W      = 4;
  localparam int YEAR_W     = 14;
  localparam int WD_W       = 3;
  localparam int MASK_W     = 7;
  localparam int IN_BITS    = DAY_W + MON_W + YEAR_W + DAYS_WIDTH;
  localparam int IN_W       = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = DAY_W + MON_W + YEAR_W + WD_W;
  localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8;

  // Shared multiplier
  localparam int MUL_W  = 14;
  localparam int PROD_W = 2 * MUL_W;

  // Reciprocal constants: x/100 = (x*5243)>>19 for x < 2^14, x/7 = (x*9363)>>16 for x < 13110
  localparam logic [MUL_W-1:0] RECIP_100 = 14'd5243;
  localparam int               SHIFT_100 = 19;
  localparam logic [MUL_W-1:0] RECIP_7   = 14'd9363;
  localparam int               SHIFT_7   = 16;
  localparam int               Q100_W    = 8;
  localparam int               Q7_W      = 11;

  // Calendar constants
  localparam logic [MON_W-1:0]  MON_JAN  = 4'd1;
  localparam logic [MON_W-1:0]  MON_FEB  = 4'd2;
  localparam logic [MON_W-1:0]  MON_MAR  = 4'd3;
  localparam logic [MON_W-1:0]  MON_DEC  = 4'd12;
  localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;
  localparam logic [WD_W-1:0]   WD_SAT   = 3'd6;

  localparam logic [MASK_W-1:0] MASK_ALL   = 7'h7F;
  localparam logic [MASK_W-1:0] MASK_RESET = 7'd96;

  // Year residues kept alongside the running date
  typedef struct packed {
    logic [1:0] r4;
    logic [6:0] r100;
    logic [8:0] r400;
  } yres_t;

  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [MON_W-1:0]  month;
    logic [DAY_W-1:0]  day;
  } date_t;

  // Control from the sequencer to the calendar counter
  typedef struct packed {
    logic load_date;
    logic load_wd;
    logic step;
  } cal_ctrl_t;

  // Leap year from the year's residues mod 4, 100, 400
  function automatic logic is_leap(input yres_t r);
    is_leap = ((r.r4 == 2'd0) && (r.r100 != 7'd0)) || (r.r400 == 9'd0);
  endfunction

  function automatic logic [DAY_W-1:0] days_in_month(input logic [MON_W-1:0] m,
                                                     input logic leap);
    case (m)
      4'd2:    days_in_month = leap ? 5'd29 : 5'd28;
      4'd4,
      4'd6,
      4'd9,
      4'd11:   days_in_month = 5'd30;
      default: days_in_month = 5'd31;
    endcase
  endfunction

  // (31*mm)/12 of the month-shift formula, keyed by the calendar month
  function automatic logic [DAY_W-1:0] month_shift(input logic [MON_W-1:0] m);
    case (m)
      4'd1:    month_shift = 5'd28;
      4'd2:    month_shift = 5'd31;
      4'd3:    month_shift = 5'd2;
      4'd4:    month_shift = 5'd5;
      4'd5:    month_shift = 5'd7;
      4'd6:    month_shift = 5'd10;
      4'd7:    month_shift = 5'd12;
      4'd8:    month_shift = 5'd15;
      4'd9:    month_shift = 5'd18;
      4'd10:   month_shift = 5'd20;
      4'd11:   month_shift = 5'd23;
      4'd12:   month_shift = 5'd25;
      default: month_shift = 5'd0;
    endcase
  endfunction

endpackage

@@ rtl/bdrd_mul.sv @@
// Shared 14x14 multiplier with a registered product.
// Depends on bdrd_pkg.
module bdrd_mul (
  input  logic                      clk,
  input  logic [bdrd_pkg::MUL_W-1:0]  a,
  input  logic [bdrd_pkg::MUL_W-1:0]  b,
  output logic [bdrd_pkg::PROD_W-1:0] p
);
  import bdrd_pkg::*;

  // Product register: the product appears in the cycle after the operands
  always_ff @(posedge clk) begin
    p <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

@@ rtl/bdrd_cal.sv @@
// Running date counter: day, month, year, year residues and weekday, one day per step.
// Depends on bdrd_pkg.
module bdrd_cal (
  input  logic                      clk,
  input  bdrd_pkg::cal_ctrl_t       ctrl,
  input  bdrd_pkg::date_t           date_in,
  input  bdrd_pkg::yres_t           res_in,
  input  logic [bdrd_pkg::WD_W-1:0] wd_in,
  output bdrd_pkg::date_t           date,
  output logic [bdrd_pkg::WD_W-1:0] wd
);
  import bdrd_pkg::*;

  date_t            date_next;
  yres_t            res, res_next;
  logic [WD_W-1:0]  wd_next;
  logic [DAY_W-1:0] dim;

  assign dim = days_in_month(date.month, is_leap(res));

  // Next calendar day
  always_comb begin
    date_next = date;
    res_next  = res;
    if (date.day >= dim) begin
      date_next.day = 5'd1;
      if (date.month == MON_DEC) begin
        date_next.month = MON_JAN;
        date_next.year  = date.year + 14'd1;
        res_next.r4     = res.r4 + 2'd1;
        res_next.r100   = (res.r100 == 7'd99)  ? 7'd0 : res.r100 + 7'd1;
        res_next.r400   = (res.r400 == 9'd399) ? 9'd0 : res.r400 + 9'd1;
      end else begin
        date_next.month = date.month + 4'd1;
      end
    end else begin
      date_next.day = date.day + 5'd1;
    end
    wd_next = (wd == WD_SAT) ? 3'd0 : wd + 3'd1;
  end

  // Date registers
  always_ff @(posedge clk) begin
    if (ctrl.load_date) begin
      date <= date_in;
      res  <= res_in;
    end else if (ctrl.step) begin
      date <= date_next;
      res  <= res_next;
    end
    if (ctrl.load_wd) begin
      wd <= wd_in;
    end else if (ctrl.step) begin
      wd <= wd_next;
    end
  end

endmodule

@@ rtl/business_day_return_date_top.sv @@
// Business-day return date: validates the start date, finds its weekday with the shared
// multiplier, then walks one calendar day per cycle. States after the transfer in: LOAD,
// CHECK, SUM, MOD, WDAY, WALK, DONE; a bad date goes from CHECK, an all-weekend mask from
// WDAY, straight to DONE, whose exit registers m_axis_tvalid. The walk is about 5740 days
// at most for 4095 business days with the reset mask, about 28670 with one business day a
// week. One item at a time; s_axis_tready is high only while idle. rst (synchronous,
// active high) clears the sequencer and output valid and sets weekend_mask to 96.
module business_day_return_date_top (
  input  logic                            clk,
  input  logic                            rst,
  // Input: day[4:0], month[8:5], year[22:9], vacation_days[34:23], zero pad
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [bdrd_pkg::IN_W-1:0]       s_axis_tdata,
  // Output: day[4:0], month[8:5], year[22:9], weekday[25:23], zero pad
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [bdrd_pkg::OUT_W-1:0]      m_axis_tdata,
  // Output flag: bad_date
  output logic                            m_axis_tuser,
  // Weekend mask write
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bdrd_pkg::MASK_W-1:0]     cfg_data
);
  import bdrd_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_LOAD  = 8'b0000_0010,
    ST_CHECK = 8'b0000_0100,
    ST_SUM   = 8'b0000_1000,
    ST_MOD   = 8'b0001_0000,
    ST_WDAY  = 8'b0010_0000,
    ST_WALK  = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_t;

  state_t              st, st_next;
  logic [MASK_W-1:0]   weekend_mask;
  date_t               in_date;
  logic [DAYS_WIDTH-1:0] left, left_next;
  logic [YEAR_W-1:0]   sum_reg;
  logic                bad;

  logic [MUL_W-1:0]    mul_a, mul_b;
  logic [PROD_W-1:0]   prod;
  cal_ctrl_t           cal_ctrl;
  yres_t               yres;
  date_t               cal_date;
  logic [WD_W-1:0]     cal_wd, wd_calc;

  logic [Q100_W-1:0]   q100;
  logic [Q7_W-1:0]     q7;
  logic [YEAR_W-1:0]   r100_w, r400_w, yy, sum_w, wd_w;
  logic                before_mar, date_ok, off_day, out_free;

  assign s_axis_tready = (st == ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // Weekend mask register
  always_ff @(posedge clk) begin
    if (rst) begin
      weekend_mask <= MASK_RESET;
    end else if (cfg_valid) begin
      weekend_mask <= cfg_data;
    end
  end

  // Quotients from the shared multiplier
  assign q100 = prod[SHIFT_100 +: Q100_W];
  assign q7   = prod[SHIFT_7 +: Q7_W];

  // Year residues and start-date check
  assign r100_w     = in_date.year - YEAR_W'(q100) * 14'd100;
  assign r400_w     = in_date.year - YEAR_W'(q100[Q100_W-1:2]) * 14'd400;
  assign yres.r4    = in_date.year[1:0];
  assign yres.r100  = r100_w[6:0];
  assign yres.r400  = r400_w[8:0];
  assign date_ok    = (in_date.month >= MON_JAN) && (in_date.month <= MON_DEC) &&
                      (in_date.year != 14'd0) && (in_date.year <= YEAR_MAX) &&
                      (in_date.day != 5'd0) &&
                      (in_date.day <= days_in_month(in_date.month, is_leap(yres)));

  // Month-shift weekday sum
  assign before_mar = (in_date.month < MON_MAR);
  assign yy         = in_date.year - YEAR_W'(before_mar);
  assign sum_w      = YEAR_W'(in_date.day) + yy + (yy >> 2) - YEAR_W'(q100) +
                      YEAR_W'(q100[Q100_W-1:2]) + YEAR_W'(month_shift(in_date.month));
  assign wd_w       = sum_reg - YEAR_W'(q7) * 14'd7;
  assign wd_calc    = wd_w[WD_W-1:0];

  assign off_day    = weekend_mask[cal_wd];

  // Multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st)
      ST_LOAD: begin
        mul_a = in_date.year;
        mul_b = RECIP_100;
      end
      ST_CHECK: begin
        mul_a = yy;
        mul_b = RECIP_100;
      end
      ST_MOD: begin
        mul_a = sum_reg;
        mul_b = RECIP_7;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  bdrd_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  bdrd_cal u_cal (
    .clk     (clk),
    .ctrl    (cal_ctrl),
    .date_in (in_date),
    .res_in  (yres),
    .wd_in   (wd_calc),
    .date    (cal_date),
    .wd      (cal_wd)
  );

  // Sequencer
  always_comb begin
    st_next   = st;
    left_next = left;
    cal_ctrl  = '0;
    case (st)
      ST_IDLE: begin
        if (s_axis_tvalid) st_next = ST_LOAD;
      end
      ST_LOAD: begin
        st_next = ST_CHECK;
      end
      ST_CHECK: begin
        cal_ctrl.load_date = 1'b1;
        st_next = date_ok ? ST_SUM : ST_DONE;
      end
      ST_SUM: begin
        st_next = ST_MOD;
      end
      ST_MOD: begin
        st_next = ST_WDAY;
      end
      ST_WDAY: begin
        cal_ctrl.load_wd = 1'b1;
        st_next = (weekend_mask == MASK_ALL) ? ST_DONE : ST_WALK;
      end
      ST_WALK: begin
        if (left != '0) begin
          cal_ctrl.step = 1'b1;
          if (!off_day) left_next = left - 1'b1;
        end else if (off_day) begin
          cal_ctrl.step = 1'b1;
        end else begin
          st_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) st_next = ST_IDLE;
      end
      default: begin
        st_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
    end else begin
      st <= st_next;
    end
  end

  // Item registers
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_date.day   <= s_axis_tdata[DAY_W-1:0];
      in_date.month <= s_axis_tdata[DAY_W +: MON_W];
      in_date.year  <= s_axis_tdata[DAY_W+MON_W +: YEAR_W];
      left          <= s_axis_tdata[DAY_W+MON_W+YEAR_W +: DAYS_WIDTH];
    end else begin
      left <= left_next;
    end
    if (st == ST_CHECK) bad <= !date_ok;
    if (st == ST_SUM)   sum_reg <= sum_w;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (st == ST_DONE && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st == ST_DONE && out_free) begin
      m_axis_tuser <= bad;
      if (bad) begin
        m_axis_tdata <= OUT_W'({3'd0, in_date.year, in_date.month, in_date.day});
      end else begin
        m_axis_tdata <= OUT_W'({cal_wd, cal_date.year, cal_date.month, cal_date.day});
      end
    end
  end

endmodule

@@ rtl/bdrd_checker.sv @@
// Port-level checks for business_day_return_date_top, attached by bind.
// Depends on bdrd_pkg.
module bdrd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [bdrd_pkg::OUT_W-1:0]  m_axis_tdata,
  input logic                        m_axis_tuser
);
  import bdrd_pkg::*;

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
    $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // One item at a time: busy right after a transfer in
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after a transfer");

  // Bad start date reports weekday zero
  a_bad_wd: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[25:23] == 3'd0)
    else $error("bad date with nonzero weekday");

  // Good result has a nonzero day, a month from 1 to 12 and a weekday below 7
  a_good: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[25:23] != 3'd7 &&
    m_axis_tdata[4:0] != 5'd0 && m_axis_tdata[8:5] != 4'd0 &&
    m_axis_tdata[8:5] != 4'd13 && m_axis_tdata[8:5] != 4'd14 && m_axis_tdata[8:5] != 4'd15)
    else $error("result is not a valid date");

endmodule

bind business_day_return_date_top bdrd_checker u_bdrd_checker (.*);

@@ tb/tb_business_day_return_date_top.sv @@
// Testbench for business_day_return_date_top: directed and random trips checked against
// a calendar walker kept in the bench, under several weekend masks.
// Depends on bdrd_pkg (field widths, mask constants) and the RTL top level.
module tb_business_day_return_date_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bdrd_pkg::*;

  // One request: packed so that the day sits in the lowest bits
  typedef struct packed {
    logic [DAYS_WIDTH-1:0] vdays;
    logic [YEAR_W-1:0]     year;
    logic [MON_W-1:0]      month;
    logic [DAY_W-1:0]      day;
  } trip_t;

  // One result: bad_date on top, then the tdata fields
  typedef struct packed {
    logic              bad;
    logic [WD_W-1:0]   wd;
    logic [YEAR_W-1:0] year;
    logic [MON_W-1:0]  month;
    logic [DAY_W-1:0]  day;
  } ret_t;

  localparam int DRAIN_CYCLES = 50;

  logic              clk;
  logic              rst;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [OUT_W-1:0]  m_axis_tdata;
  logic              m_axis_tuser;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [MASK_W-1:0] cfg_data;

  logic [MASK_W-1:0] off_days;      // bench copy of weekend_mask
  ret_t              pending_returns[$];
  int                mismatch_count;
  bit                idle_on;
  int                rx_hold;

  business_day_return_date_top dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- calendar walker
  function automatic bit leap_yr(input int y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  function automatic int month_length(input int m, input int y);
    case (m)
      2:          return leap_yr(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:    return 31;
    endcase
  endfunction

  function automatic ret_t predict_return(input trip_t t, input logic [MASK_W-1:0] mask);
    ret_t r;
    int   d, m, y, left, wd, a, yy, mm;
    d    = t.day;
    m    = t.month;
    y    = t.year;
    left = t.vdays;
    r    = '0;
    // invalid start date echoes the input with the flag set
    if (m < 1 || m > 12 || y < 1 || y > 9999 || d < 1 || d > month_length(m, y)) begin
      r.day   = t.day;
      r.month = t.month;
      r.year  = t.year;
      r.bad   = 1'b1;
      return r;
    end
    // month-shift weekday of the start date
    a  = (14 - m) / 12;
    yy = y - a;
    mm = m + 12 * a - 2;
    wd = (d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7;
    // consume business days, then skip to the next business day
    if (mask != MASK_ALL) begin
      while (left != 0 || mask[wd]) begin
        if (left != 0 && !mask[wd]) left--;
        if (d >= month_length(m, y)) begin
          d = 1;
          if (m == 12) begin
            m = 1;
            y++;
          end else begin
            m++;
          end
        end else begin
          d++;
        end
        wd = (wd + 1) % 7;
      end
    end
    r.day   = d[DAY_W-1:0];
    r.month = m[MON_W-1:0];
    r.year  = y[YEAR_W-1:0];
    r.wd    = wd[WD_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers
  function automatic trip_t mk_trip(input int d, input int m, input int y, input int v);
    trip_t t;
    t.day   = d[DAY_W-1:0];
    t.month = m[MON_W-1:0];
    t.year  = y[YEAR_W-1:0];
    t.vdays = v[DAYS_WIDTH-1:0];
    return t;
  endfunction

  // Send one trip; the expectation is queued at the accepting edge
  task automatic send_trip(input trip_t t);
    if (idle_on && $urandom_range(0, 2) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = IN_W'(t);
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_returns.push_back(predict_return(t, off_days));
    @(negedge clk);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic wait_drain();
    while (pending_returns.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Mask writes happen only with the block idle
  task automatic write_weekend_mask(input logic [MASK_W-1:0] mask);
    wait_drain();
    cfg_valid = 1'b1;
    cfg_data  = mask;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    off_days = mask;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Receiver stalls in random bursts while idle_on is set
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold--;
      m_axis_tready = 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      rx_hold = $urandom_range(0, 3);
      m_axis_tready = 1'b0;
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    ret_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = ret_t'({m_axis_tuser, m_axis_tdata[OUT_BITS-1:0]});
      if (pending_returns.size() == 0) begin
        report_mismatch("unexpected result, day", got.day, 0);
      end else begin
        want = pending_returns.pop_front();
        if (got.day !== want.day)     report_mismatch("return_day", got.day, want.day);
        if (got.month !== want.month) report_mismatch("return_month", got.month, want.month);
        if (got.year !== want.year)   report_mismatch("return_year", got.year, want.year);
        if (got.wd !== want.wd)       report_mismatch("return_weekday", got.wd, want.wd);
        if (got.bad !== want.bad)     report_mismatch("bad_date", got.bad, want.bad);
      end
    end
  end

  // ---------------------------------------------------------------- tests
  // Month, year and leap boundaries, zero and maximal counts, default mask
  task automatic test_calendar_edges();
    send_trip(mk_trip(1, 1, 1, 0));
    send_trip(mk_trip(1, 1, 2024, 0));        // Monday, already a business day
    send_trip(mk_trip(5, 1, 2024, 0));        // Friday, skips to Sunday
    send_trip(mk_trip(31, 1, 2024, 1));
    send_trip(mk_trip(28, 2, 2023, 1));
    send_trip(mk_trip(29, 2, 2024, 3));
    send_trip(mk_trip(29, 2, 2000, 10));      // leap by the 400 rule
    send_trip(mk_trip(31, 12, 2023, 1));
    send_trip(mk_trip(31, 12, 9999, 4095));   // walks past year 9999
    send_trip(mk_trip(30, 4, 1900, 2000));
  endtask

  // Start dates that are rejected
  task automatic test_invalid_dates();
    send_trip(mk_trip(29, 2, 1900, 5));       // century, not leap
    send_trip(mk_trip(0, 6, 2020, 5));
    send_trip(mk_trip(31, 4, 2020, 5));
    send_trip(mk_trip(10, 0, 2020, 5));
    send_trip(mk_trip(10, 13, 2020, 5));
    send_trip(mk_trip(10, 5, 0, 5));
    send_trip(mk_trip(10, 5, 10000, 5));
    send_trip(mk_trip(31, 15, 16383, 4095));  // every input bit set
  endtask

  // No weekend, all weekend, and a single business day per week
  task automatic test_mask_extremes();
    write_weekend_mask('0);
    send_trip(mk_trip(15, 3, 2021, 40));
    send_trip(mk_trip(28, 2, 2100, 1));
    write_weekend_mask(MASK_ALL);
    send_trip(mk_trip(17, 8, 1999, 4095));    // nothing is a business day
    send_trip(mk_trip(30, 2, 2004, 7));
    write_weekend_mask(7'h7E);                // Sundays only
    send_trip(mk_trip(3, 7, 1776, 4095));
    send_trip(mk_trip(9, 11, 5000, 0));
  endtask

  function automatic trip_t rand_trip();
    trip_t t;
    int    y, m, kind;
    kind = $urandom_range(0, 19);
    if (kind < 2) begin
      // raw noise over the whole field ranges
      t = trip_t'($urandom);
      t.vdays = DAYS_WIDTH'($urandom_range(0, 4095));
      if ($urandom_range(0, 3) != 0) t.vdays = DAYS_WIDTH'($urandom_range(0, 40));
      return t;
    end
    case ($urandom_range(0, 7))
      0:       y = 1;
      1:       y = 9999;
      2:       y = 100 * $urandom_range(1, 99);
      default: y = $urandom_range(1, 9999);
    endcase
    m = $urandom_range(1, 12);
    t.year  = y[YEAR_W-1:0];
    t.month = m[MON_W-1:0];
    if (kind < 4) t.day = DAY_W'($urandom_range(0, 31));   // may run past the month end
    else          t.day = DAY_W'($urandom_range(1, month_length(m, y)));
    if ($urandom_range(0, 15) == 0) t.vdays = DAYS_WIDTH'($urandom_range(0, 4095));
    else                            t.vdays = DAYS_WIDTH'($urandom_range(0, 40));
    return t;
  endfunction

  // Random trips under the reset mask, then random masks; the last phase runs without idling
  task automatic test_random_trips();
    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 0)      write_weekend_mask(MASK_RESET);
      else if (ph == 4) write_weekend_mask(MASK_W'($urandom_range(0, 127)));
      else              write_weekend_mask(MASK_W'($urandom_range(0, 127)));
      if (ph == 4) idle_on = 1'b0;
      for (int k = 0; k < 16; k++) send_trip(rand_trip());
    end
  endtask

  // ---------------------------------------------------------------- main
  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    m_axis_tready  = 1'b0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    off_days       = MASK_RESET;
    mismatch_count = 0;
    idle_on        = 1'b1;
    rx_hold        = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_calendar_edges();
    test_invalid_dates();
    test_mask_extremes();
    test_random_trips();

    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run (every item walking a one-day-a-week mask)
  initial begin
    #150ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
